// ----- design/sfd_pkg.sv -----
// Shared constants and types for the SBUS frame decoder.
// Used by sbus_frame_decoder_top, its port checker and the testbench; no other dependencies.

package sfd_pkg;

	// Frame marker bytes
	localparam logic [7:0] START_BYTE = 8'h0F;
	localparam logic [7:0] FLAGS_BYTE = 8'h00;

	// Frame geometry: 22 data bytes, of which the first 11 carry eight channels
	localparam logic [4:0] DATA_LEN   = 5'd22;
	localparam int         KEPT_BYTES = 11;
	localparam logic [4:0] KEPT_LEN   = 5'(KEPT_BYTES);
	localparam int         CH_W       = 11;
	localparam int         NUM_CH     = 8;
	localparam int         OUT_W      = CH_W * NUM_CH;

	// Reset value of the glitch limit register
	localparam logic [CH_W-1:0] LIMIT_RESET = 11'd400;

	typedef logic [CH_W-1:0] chan_t;

endpackage

// ----- design/sbus_frame_decoder_top.sv -----
// A result beat is presented in the cycle after the beat carrying the byte that follows the
// flags byte. Throughput: one received byte per cycle unless stalled; each byte updates the
// parser in a single pass of logic between the input handshake and the result register.
// The input stalls only on that one byte while the previous result is still unread.
// Reset (arst_n low) returns the parser to hunting, clears the held channel and the result
// valid, and loads the glitch limit with 400; the kept data bytes are not cleared.

module sbus_frame_decoder_top (
	input  logic                      clk,
	input  logic                      arst_n,
	// Received byte stream
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata,   // [7:0] rx_byte
	// Decoded channel stream
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// [10:0] out_ch0, [21:11] out_ch1, [32:22] out_ch2, [43:33] out_ch3,
	// [54:44] out_ch4, [65:55] out_ch5, [76:66] out_ch6, [87:77] out_ch7
	output logic [sfd_pkg::OUT_W-1:0] m_tdata,
	// Glitch limit register write
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [sfd_pkg::CH_W-1:0]  cfg_data   // [10:0] glitch_limit
);

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_COLLECT = 2'd1,
		PH_EMIT    = 2'd2
	} phase_t;

	phase_t                 phase_q;
	logic [4:0]             byte_count_q;
	logic [7:0]             frame_q [0:sfd_pkg::KEPT_BYTES-1];
	sfd_pkg::chan_t         held_q;
	sfd_pkg::chan_t         limit_q;
	logic                   out_valid_q;
	logic [sfd_pkg::OUT_W-1:0] out_data_q;

	logic                   in_beat;
	logic                   out_free;
	logic [sfd_pkg::OUT_W-1:0] kept_bits;
	sfd_pkg::chan_t         ch [0:sfd_pkg::NUM_CH-1];
	sfd_pkg::chan_t         diff;
	sfd_pkg::chan_t         ch2_sel;
	logic [4:0]             count_next;

	// The configuration register is always writable
	assign cfg_ready = 1'b1;

	// Only the byte that completes a frame needs room in the result register
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (phase_q != PH_EMIT) || out_free;
	assign in_beat  = s_tvalid && s_tready;

	// Kept bytes form one little-endian bit vector; channel k sits at bit 11k
	always_comb begin
		for (int i = 0; i < sfd_pkg::KEPT_BYTES; i++) begin
			kept_bits[i*8 +: 8] = frame_q[i];
		end
		for (int k = 0; k < sfd_pkg::NUM_CH; k++) begin
			ch[k] = kept_bits[k*sfd_pkg::CH_W +: sfd_pkg::CH_W];
		end
	end

	// Glitch hold on protocol channel 2: keep the old value on a jump beyond the limit
	always_comb begin
		diff    = (ch[2] > held_q) ? (ch[2] - held_q) : (held_q - ch[2]);
		ch2_sel = (diff > limit_q) ? held_q : ch[2];
	end

	assign count_next = byte_count_q + 5'd1;

	// Parser state, held channel and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			byte_count_q <= '0;
			held_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// A new result is loaded on the emitting beat, otherwise a taken one is dropped
			if (in_beat && phase_q == PH_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (in_beat) begin
				unique case (phase_q)
					PH_COLLECT: begin
						if (s_tdata == sfd_pkg::FLAGS_BYTE &&
						    byte_count_q == sfd_pkg::DATA_LEN) begin
							phase_q <= PH_EMIT;
						end else if (count_next > sfd_pkg::DATA_LEN) begin
							// Flags byte missing: resynchronise
							byte_count_q <= '0;
							phase_q      <= PH_HUNT;
						end else begin
							byte_count_q <= count_next;
						end
					end
					PH_EMIT: begin
						phase_q      <= PH_HUNT;
						byte_count_q <= '0;
						held_q       <= ch2_sel;
					end
					default: begin
						// Hunting, and the unused phase code behaves the same
						phase_q <= (s_tdata == sfd_pkg::START_BYTE) ? PH_COLLECT : PH_HUNT;
					end
				endcase
			end
		end
	end

	// Result payload in output order
	always_ff @(posedge clk) begin
		if (in_beat && phase_q == PH_EMIT) begin
			out_data_q <= {ch[1], ch2_sel, ch[0], ch[3], ch[6], ch[5], ch[4], ch[7]};
		end
	end

	// Data bytes of the current frame; only the first eleven are kept
	always_ff @(posedge clk) begin
		if (in_beat && phase_q == PH_COLLECT && byte_count_q < sfd_pkg::KEPT_LEN &&
		    !(s_tdata == sfd_pkg::FLAGS_BYTE && byte_count_q == sfd_pkg::DATA_LEN)) begin
			frame_q[byte_count_q[3:0]] <= s_tdata;
		end
	end

	// Glitch limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= sfd_pkg::LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ----- design/sfd_checker.sv -----
// Port-level checks for the SBUS frame decoder, bound to sbus_frame_decoder_top.
// Depends on sfd_pkg for the result width.

module sfd_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic [7:0]                s_tdata,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [sfd_pkg::OUT_W-1:0] m_tdata,
	input logic                      cfg_valid,
	input logic                      cfg_ready,
	input logic [sfd_pkg::CH_W-1:0]  cfg_data
);

	// A result that is not taken stays offered with the same payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// The input only stalls behind an unread result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a pending result");

	// A new result appears only right after an input beat
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready))
		else $error("result appeared without an input beat");

	// Configuration writes are never refused
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind sbus_frame_decoder_top sfd_checker u_sfd_checker (.*);

// ----- tb/sv/tb_sbus_frame_decoder_top.sv -----
// Self-checking testbench for sbus_frame_decoder_top: byte frames in, decoded channels out.
// Depends on sfd_pkg and the decoder RTL only; prediction runs in a small scoreboard class.

module tb_sbus_frame_decoder_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_DATA         = int'(sfd_pkg::DATA_LEN);
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int N_PHASES       = 6;
	localparam int FRAMES_PER_SET = 4;

	typedef enum logic [1:0] {HUNTING, COLLECTING, AWAIT_TAIL} parse_phase_t;
	typedef logic [sfd_pkg::NUM_CH-1:0][sfd_pkg::CH_W-1:0] frame_chans_t;

	// Parser predictor and queue of expected channel beats
	class frame_scoreboard;
		parse_phase_t   phase;
		logic [4:0]     count;
		logic [7:0]     kept [sfd_pkg::KEPT_BYTES];
		sfd_pkg::chan_t held;
		sfd_pkg::chan_t limit;
		int             errors;
		int             frames_predicted;
		frame_chans_t   expected_frames [$];

		function new();
			phase            = HUNTING;
			count            = '0;
			held             = '0;
			limit            = sfd_pkg::LIMIT_RESET;
			errors           = 0;
			frames_predicted = 0;
			foreach (kept[j]) kept[j] = '0;
		endfunction

		function int pending();
			return expected_frames.size();
		endfunction

		// Advance the parser by one accepted byte; the byte after the flags byte emits a frame.
		function void note_byte(logic [7:0] b);
			logic [8*sfd_pkg::KEPT_BYTES-1:0] raw;
			sfd_pkg::chan_t                   ch [sfd_pkg::NUM_CH];
			sfd_pkg::chan_t                   c2;
			int unsigned                      diff;
			frame_chans_t                     f;
			unique case (phase)
				COLLECTING: begin
					if (b == sfd_pkg::FLAGS_BYTE && count == sfd_pkg::DATA_LEN) begin
						phase = AWAIT_TAIL;
					end else begin
						if (count < sfd_pkg::KEPT_LEN)
							kept[count] = b;
						count = count + 5'd1;
						if (count > sfd_pkg::DATA_LEN) begin
							count = '0;
							phase = HUNTING;
						end
					end
				end
				AWAIT_TAIL: begin
					phase = HUNTING;
					count = '0;
					for (int j = 0; j < sfd_pkg::KEPT_BYTES; j++)
						raw[8*j +: 8] = kept[j];
					for (int k = 0; k < sfd_pkg::NUM_CH; k++)
						ch[k] = raw[sfd_pkg::CH_W*k +: sfd_pkg::CH_W];
					// Channel 2 keeps its old value when it jumps by more than the limit
					c2   = ch[2];
					diff = (c2 > held) ? int'(c2 - held) : int'(held - c2);
					if (diff > int'(limit))
						c2 = held;
					held = c2;
					f[0] = ch[7];
					f[1] = ch[4];
					f[2] = ch[5];
					f[3] = ch[6];
					f[4] = ch[3];
					f[5] = ch[0];
					f[6] = c2;
					f[7] = ch[1];
					expected_frames.push_back(f);
					frames_predicted++;
				end
				default: begin
					phase = (b == sfd_pkg::START_BYTE) ? COLLECTING : HUNTING;
				end
			endcase
		endfunction

		// Compare one accepted output beat with the oldest expected frame.
		function void check_frame(frame_chans_t got);
			frame_chans_t exp_f;
			if (expected_frames.size() == 0) begin
				$display("%0t: unexpected output beat %h", $realtime, got);
				errors++;
				return;
			end
			exp_f = expected_frames.pop_front();
			for (int f = 0; f < sfd_pkg::NUM_CH; f++) begin
				if (got[f] !== exp_f[f]) begin
					$display("%0t: out_ch%0d expected %0d, got %0d", $realtime, f, exp_f[f],
						got[f]);
					errors++;
				end
			end
		endfunction
	endclass

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        s_tvalid  = 1'b0;
	logic                        s_tready;
	logic [7:0]                  s_tdata   = '0;
	logic                        m_tvalid;
	logic                        m_tready  = 1'b0;
	logic [sfd_pkg::OUT_W-1:0]   m_tdata;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [sfd_pkg::CH_W-1:0]    cfg_data  = '0;

	frame_scoreboard sb = new();
	bit              quiet = 1'b0;
	int              stall_left = 0;
	int              stuck_cycles = 0;

	sbus_frame_decoder_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Output side: random ready with the odd long stall, none while quiet.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if (!quiet && $urandom_range(199) == 0) begin
			stall_left <= $urandom_range(40, 10);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= quiet || ($urandom_range(99) >= 31);
		end
	end

	// Check output beats and watch for a stalled handshake.
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_frame(frame_chans_t'(m_tdata));
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Present one byte, idling at random beforehand; returns at the falling edge after the beat.
	task automatic send_byte(input logic [7:0] b);
		if (!quiet) begin
			while ($urandom_range(99) < 31) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_byte(b);
		@(negedge clk);
	endtask

	// Start byte, the data bytes, then the given flags byte and tail byte.
	task automatic send_frame(input logic [7:0] data [N_DATA], input logic [7:0] flags,
			input logic [7:0] tail);
		send_byte(sfd_pkg::START_BYTE);
		for (int j = 0; j < N_DATA; j++)
			send_byte(data[j]);
		send_byte(flags);
		send_byte(tail);
	endtask

	// Hold the sender until every expected frame has come out and the block has settled.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_limit(input logic [sfd_pkg::CH_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.limit = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Data bytes lean towards the marker values and the extremes.
	function automatic logic [7:0] pick_data_byte();
		case ($urandom_range(9))
			0: return sfd_pkg::FLAGS_BYTE;
			1: return sfd_pkg::START_BYTE;
			2: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// One random piece of traffic: mostly good frames, some broken ones and line noise.
	task automatic send_random_traffic();
		logic [7:0] data [N_DATA];
		logic [7:0] b;
		int         kind;
		int         target;
		int         n_bytes;
		kind = $urandom_range(99);
		for (int j = 0; j < N_DATA; j++)
			data[j] = pick_data_byte();
		if (kind < 80) begin
			// Aim channel 2 at the edges of the hold window now and then
			if ($urandom_range(99) < 40) begin
				case ($urandom_range(4))
					0: target = int'(sb.held) + int'(sb.limit);
					1: target = int'(sb.held) + int'(sb.limit) + 1;
					2: target = int'(sb.held) - int'(sb.limit);
					3: target = int'(sb.held) - int'(sb.limit) - 1;
					default: target = int'(sb.held);
				endcase
				if (target < 0)
					target = 0;
				if (target > 2047)
					target = 2047;
				data[2][7:6] = 2'(target);
				data[3]      = 8'(target >> 2);
				data[4][0]   = 1'(target >> 10);
			end
			send_frame(data, sfd_pkg::FLAGS_BYTE, 8'($urandom_range(255)));
		end else if (kind < 90) begin
			// Missing flags byte: the parser resynchronises
			send_frame(data, 8'($urandom_range(255, 1)), 8'($urandom_range(255)));
		end else if (kind < 95) begin
			// Frame cut short; the next frame's bytes run on as data
			n_bytes = $urandom_range(21, 1);
			send_byte(sfd_pkg::START_BYTE);
			for (int j = 0; j < n_bytes; j++)
				send_byte(data[j]);
		end else begin
			n_bytes = $urandom_range(4, 1);
			for (int j = 0; j < n_bytes; j++) begin
				do
					b = 8'($urandom_range(255));
				while (b == sfd_pkg::START_BYTE);
				send_byte(b);
			end
		end
	endtask

	initial begin
		logic [7:0]  data [N_DATA];
		logic [10:0] limits [N_PHASES];
		int          frames_at_start;
		int          pieces;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: ignored bytes while hunting, then one frame with zero bytes kept as data
		send_byte(8'h00);
		send_byte(8'hFF);
		for (int j = 0; j < N_DATA; j++)
			data[j] = (j % 2 == 1) ? 8'hFF : 8'h00;
		data[4] = 8'h55;
		data[7] = 8'hAA;
		send_frame(data, sfd_pkg::FLAGS_BYTE, 8'hFF);

		// Limit settings per phase; the first phase keeps the reset value
		limits[0] = sfd_pkg::LIMIT_RESET;
		limits[1] = 11'd0;
		limits[2] = 11'd2047;
		limits[3] = 11'($urandom_range(2047));
		limits[4] = 11'd1;
		limits[5] = 11'($urandom_range(300));

		for (int p = 0; p < N_PHASES; p++) begin
			if (p > 0) begin
				wait_drained();
				write_limit(limits[p]);
			end
			quiet = (p == 2);
			frames_at_start = sb.frames_predicted;
			pieces = 0;
			while (sb.frames_predicted - frames_at_start < FRAMES_PER_SET) begin
				send_random_traffic();
				pieces++;
				if (p == 3 && pieces == 4)
					wait_drained();
			end
		end
		quiet = 1'b0;

		// Let the last frames out, then report
		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- sbus_frame_decoder_top.f -----
design/sfd_pkg.sv
design/sbus_frame_decoder_top.sv
design/sfd_checker.sv
tb/sv/tb_sbus_frame_decoder_top.sv
